@@ rtl/skt_pkg.sv @@
// Package for the sorted key table: field widths, operation and status codes,
// and the structs passed between the top level and the table cells.
// Depends on nothing.
package skt_pkg;

    localparam int CAPACITY_DEF = 16;
    localparam int KEY_W        = 16;
    localparam int PAY_W        = 32;
    localparam int COUNT_W      = 5;
    localparam int STATUS_W     = 2;

    // Operation codes of an input transaction.
    localparam logic OP_ADD  = 1'b0;
    localparam logic OP_FIND = 1'b1;

    // Status codes of a result transaction.
    localparam logic [STATUS_W-1:0] ST_ADDED = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FOUND = 2'd2;
    localparam logic [STATUS_W-1:0] ST_MISS  = 2'd3;

    // Insert request broadcast to every cell.
    typedef struct packed {
        logic             en;
        logic [KEY_W-1:0] key;
        logic [PAY_W-1:0] pay;
    } skt_ins_t;

    // What a cell shows to its right-hand neighbor.
    typedef struct packed {
        logic             vld;
        logic             gt;
        logic [KEY_W-1:0] key;
        logic [PAY_W-1:0] pay;
    } skt_nbr_t;

    // Search token that walks down the chain one cell per cycle.
    typedef struct packed {
        logic             vld;
        logic [KEY_W-1:0] key;
        logic             hit;
        logic [PAY_W-1:0] pay;
    } skt_srch_t;

endpackage

@@ rtl/skt_ifs.sv @@
// Valid/ready channel interfaces for the sorted key table.
// Depends on skt_pkg for the field widths.
interface skt_req_if;
    import skt_pkg::*;
    logic             valid;
    logic             ready;
    logic             opcode;
    logic [KEY_W-1:0] key;
    logic [PAY_W-1:0] payload;

    modport source (output valid, output opcode, output key, output payload, input ready);
    modport sink   (input valid, input opcode, input key, input payload, output ready);
endinterface

interface skt_rsp_if;
    import skt_pkg::*;
    logic                valid;
    logic                ready;
    logic [STATUS_W-1:0] status;
    logic [PAY_W-1:0]    found_payload;
    logic [COUNT_W-1:0]  entry_count;

    modport source (output valid, output status, output found_payload, output entry_count,
                    input ready);
    modport sink   (input valid, input status, input found_payload, input entry_count,
                    output ready);
endinterface

@@ rtl/skt_cell.sv @@
// One cell of the sorted table: holds one entry, shifts it right on insert,
// and carries one stage of the search token.
// Depends on skt_pkg.
module skt_cell
    import skt_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  skt_ins_t  ins,
    input  logic      self_vld,
    input  skt_nbr_t  left,
    output skt_nbr_t  right,
    input  skt_srch_t srch_in,
    output skt_srch_t srch_out
);

    logic [KEY_W-1:0] key_reg;
    logic [PAY_W-1:0] pay_reg;
    logic             gt;
    logic             moves;
    skt_srch_t        srch_reg;
    skt_srch_t        srch_next;
    logic             match;

    // This entry must make room when its key is above the new key. The first
    // empty cell takes whatever arrives from the left or the new entry.
    assign gt    = self_vld && (key_reg > ins.key);
    assign moves = ins.en && (gt || (!self_vld && left.vld));

    // Entry storage: take the left neighbor's entry if it also shifts,
    // otherwise the new entry lands here.
    always_ff @(posedge clk)
    begin
        if (moves)
        begin
            if (left.gt)
            begin
                key_reg <= left.key;
                pay_reg <= left.pay;
            end
            else
            begin
                key_reg <= ins.key;
                pay_reg <= ins.pay;
            end
        end
    end

    assign right.vld = self_vld;
    assign right.gt  = gt;
    assign right.key = key_reg;
    assign right.pay = pay_reg;

    // Search stage: a later match overrides an earlier one.
    assign match = srch_in.vld && self_vld && (key_reg == srch_in.key);

    always_comb
    begin
        srch_next     = srch_in;
        srch_next.hit = srch_in.hit || match;
        if (match)
        begin
            srch_next.pay = pay_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            srch_reg <= '0;
        end
        else
        begin
            srch_reg <= srch_next;
        end
    end

    assign srch_out = srch_reg;

endmodule

@@ rtl/sorted_key_table_insert_find.sv @@
// Top level of the sorted key table: a chain of entry cells, the fill count,
// the search launch stage and the result register.
// Depends on skt_pkg, skt_ifs and skt_cell.
//
//   Channel | Dir | Carries                               | Handshake
//   req     | in  | opcode, key, payload                  | valid/ready
//   rsp     | out | status, found_payload, entry_count    | valid/ready
//
// On an add, every cell decides in parallel whether to shift its entry right
// or take the new one, and the result is ready the next cycle.
// A find walks a token down the chain one cell per cycle; its result is
// registered once the token leaves the last cell, and req is not ready meanwhile.
// Reset empties the table at once. A result held by a stalled rsp blocks req.
module sorted_key_table_insert_find
    import skt_pkg::*;
#(
    parameter int CAPACITY = CAPACITY_DEF
)
(
    input logic      clk,
    input logic      rst_n,
    skt_req_if.sink  req,
    skt_rsp_if.source rsp
);

    localparam int FILL_W = $clog2(CAPACITY + 1);

    logic [FILL_W-1:0]          fill_count_reg;
    logic [FILL_W-1:0]          fill_count_next;
    logic                       busy_reg;
    logic                       busy_next;
    skt_srch_t                  launch_reg;
    skt_srch_t                  launch_next;
    logic                       rsp_vld_reg;
    logic                       rsp_vld_next;
    logic [STATUS_W-1:0]        status_reg;
    logic [STATUS_W-1:0]        status_next;
    logic [PAY_W-1:0]           found_reg;
    logic [PAY_W-1:0]           found_next;
    logic [COUNT_W-1:0]         count_reg;
    logic [COUNT_W-1:0]         count_next;
    logic [FILL_W+COUNT_W-1:0]  count_ext;
    logic                       accept;
    logic                       full;
    skt_ins_t                   ins;
    skt_nbr_t                   nbr  [CAPACITY];
    skt_srch_t                  srch [CAPACITY];
    skt_srch_t                  done_tok;

    localparam skt_nbr_t LEFT_EDGE = '{vld: 1'b1, gt: 1'b0, key: '0, pay: '0};

    // Handshake and insert request.
    assign req.ready = !busy_reg && (!rsp_vld_reg || rsp.ready);
    assign accept    = req.valid && req.ready;
    assign full      = (fill_count_reg == FILL_W'(CAPACITY));

    assign ins.en  = accept && (req.opcode == OP_ADD) && !full;
    assign ins.key = req.key;
    assign ins.pay = req.payload;

    // Chain of cells; cell i holds an entry while i is below the fill count.
    for (genvar i = 0; i < CAPACITY; i++)
    begin : g_cell
        if (i == 0)
        begin : g_first
            skt_cell u_cell (
                .clk      (clk),
                .rst_n    (rst_n),
                .ins      (ins),
                .self_vld (fill_count_reg > FILL_W'(i)),
                .left     (LEFT_EDGE),
                .right    (nbr[i]),
                .srch_in  (launch_reg),
                .srch_out (srch[i])
            );
        end
        else
        begin : g_rest
            skt_cell u_cell (
                .clk      (clk),
                .rst_n    (rst_n),
                .ins      (ins),
                .self_vld (fill_count_reg > FILL_W'(i)),
                .left     (nbr[i-1]),
                .right    (nbr[i]),
                .srch_in  (srch[i-1]),
                .srch_out (srch[i])
            );
        end
    end

    assign done_tok = srch[CAPACITY-1];

    // Fill count, busy flag, search launch and result register.
    always_comb
    begin
        fill_count_next = fill_count_reg;
        busy_next       = busy_reg;
        launch_next     = '{vld: 1'b0, key: req.key, hit: 1'b0, pay: '0};
        rsp_vld_next    = rsp_vld_reg && !rsp.ready;
        status_next     = status_reg;
        found_next      = found_reg;
        if (ins.en)
        begin
            fill_count_next = fill_count_reg + FILL_W'(1);
        end
        count_ext  = {{COUNT_W{1'b0}}, fill_count_next};
        count_next = count_ext[COUNT_W-1:0];
        priority if (accept && (req.opcode == OP_ADD))
        begin
            rsp_vld_next = 1'b1;
            status_next  = full ? ST_FULL : ST_ADDED;
            found_next   = '0;
        end
        else if (accept)
        begin
            busy_next       = 1'b1;
            launch_next.vld = 1'b1;
        end
        else if (done_tok.vld)
        begin
            busy_next    = 1'b0;
            rsp_vld_next = 1'b1;
            status_next  = done_tok.hit ? ST_FOUND : ST_MISS;
            found_next   = done_tok.hit ? done_tok.pay : '0;
        end
        else
        begin
            count_next = count_reg;
        end
        if (!(accept || done_tok.vld))
        begin
            count_next = count_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_count_reg <= '0;
            busy_reg       <= 1'b0;
            launch_reg     <= '0;
            rsp_vld_reg    <= 1'b0;
        end
        else
        begin
            fill_count_reg <= fill_count_next;
            busy_reg       <= busy_next;
            launch_reg     <= launch_next;
            rsp_vld_reg    <= rsp_vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        status_reg     <= status_next;
        found_reg      <= found_next;
        count_reg      <= count_next;
    end

    assign rsp.valid         = rsp_vld_reg;
    assign rsp.status        = status_reg;
    assign rsp.found_payload = found_reg;
    assign rsp.entry_count   = count_reg;

endmodule

@@ rtl/skt_checker.sv @@
// Port-level checker for the sorted key table, bound to the top level.
// Depends on skt_pkg and sorted_key_table_insert_find.
module skt_checker
    import skt_pkg::*;
(
    input logic                clk,
    input logic                rst_n,
    input logic                req_valid,
    input logic                req_ready,
    input logic                req_opcode,
    input logic                rsp_valid,
    input logic                rsp_ready,
    input logic [STATUS_W-1:0] rsp_status,
    input logic [COUNT_W-1:0]  rsp_count
);

    // A stalled result keeps its status and entry count.
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status) && $stable(rsp_count))
        else $error("stalled result changed");

    // An add answers in the next cycle with added or full.
    a_add_resp: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready && (req_opcode == OP_ADD) |=>
        rsp_valid && ((rsp_status == ST_ADDED) || (rsp_status == ST_FULL)))
        else $error("add transaction without immediate result");

    // A find blocks new requests and shows no result in the next cycle.
    a_find_busy: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready && (req_opcode == OP_FIND) |=> !req_ready && !rsp_valid)
        else $error("find transaction did not occupy the table");

endmodule

bind sorted_key_table_insert_find skt_checker u_skt_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .req_valid  (req.valid),
    .req_ready  (req.ready),
    .req_opcode (req.opcode),
    .rsp_valid  (rsp.valid),
    .rsp_ready  (rsp.ready),
    .rsp_status (rsp.status),
    .rsp_count  (rsp.entry_count)
);
